/* rtl/spq_pkg.sv */
// Shared types and codes for the sorted priority queue.
// Used by the storage cells, the top level and the port checker.
package spq_pkg;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;
    localparam int OCC_W   = 8;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic {
        CMD_ENQUEUE = 1'b0,
        CMD_DEQUEUE = 1'b1
    } t_cmd;

    typedef struct packed {
        logic signed [PRIO_W-1:0]  prio;
        logic signed [VALUE_W-1:0] value;
    } t_entry;

    // Broadcast to every cell for the request being accepted this cycle.
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry item;
    } t_ctrl;

endpackage

/* rtl/spq_cell.sv */
// One storage cell of the sorted chain: holds an entry and picks its next
// contents from itself, its neighbours or the incoming entry. Needs spq_pkg.
module spq_cell
    import spq_pkg::*;
(
    input  logic   i_clk,
    input  t_ctrl  i_ctrl,
    input  t_entry i_left,
    input  logic   i_left_gt,
    input  t_entry i_right,
    input  logic   i_occupied,
    input  logic   i_at_tail,
    output t_entry o_entry,
    output logic   o_gt
);

    t_entry r_entry;
    t_entry n_entry;

    // The stored entry belongs to the part that moves up to make room.
    assign o_gt    = i_occupied && (r_entry.prio > i_ctrl.item.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctrl.enq) begin
            priority if (i_left_gt) begin
                n_entry = i_left;
            end else if (o_gt || i_at_tail) begin
                n_entry = i_ctrl.item;
            end
        end else if (i_ctrl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* rtl/sorted_priority_queue.sv */
// Sorted priority queue built as a chain of DEPTH storage cells kept in
// ascending priority order; equal priorities leave in arrival order. Every
// cell compares its priority with the incoming one in the same cycle, so a
// request can be accepted on every clock unless the output stalls; its
// result is in the output register in the next cycle. The input is held off
// while a result waits, and a new request is taken in the same cycle that
// the waiting result is taken. No clearing pass is needed after reset.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // item_value [31:0], item_priority [47:32]
    input  logic [0:0]  s_tuser,  // command [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // out_value [31:0], out_priority [47:32],
                                  // occupancy [55:48]
    output logic [1:0]  m_tuser   // status [1:0]
);

    localparam int CW = $clog2(DEPTH + 1);

    logic          w_accept;
    logic          w_full;
    logic          w_empty;
    t_cmd          w_cmd;
    t_ctrl         w_ctrl;
    t_entry        w_entry   [DEPTH];
    logic          w_gt      [DEPTH];
    t_entry        w_left    [DEPTH];
    logic          w_left_gt [DEPTH];
    t_entry        w_right   [DEPTH];

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_m_valid;
    logic          n_m_valid;
    t_status       r_status;
    t_status       n_status;
    t_entry        r_out;
    t_entry        n_out;
    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;

    assign s_tready = !r_m_valid || m_tready;
    assign w_accept = s_tvalid && s_tready;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_cmd    = t_cmd'(s_tuser[0]);

    assign w_ctrl.enq        = w_accept && (w_cmd == CMD_ENQUEUE) && !w_full;
    assign w_ctrl.deq        = w_accept && (w_cmd == CMD_DEQUEUE) && !w_empty;
    assign w_ctrl.item.value = s_tdata[31:0];
    assign w_ctrl.item.prio  = s_tdata[47:32];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign w_left[i]    = '0;
            assign w_left_gt[i] = 1'b0;
        end else begin : g_body
            assign w_left[i]    = w_entry[i-1];
            assign w_left_gt[i] = w_gt[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign w_right[i] = w_entry[i];
        end else begin : g_inner
            assign w_right[i] = w_entry[i+1];
        end

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_left     (w_left[i]),
            .i_left_gt  (w_left_gt[i]),
            .i_right    (w_right[i]),
            .i_occupied (r_count > CW'(i)),
            .i_at_tail  (r_count == CW'(i)),
            .o_entry    (w_entry[i]),
            .o_gt       (w_gt[i])
        );
    end

    always_comb begin
        n_count   = r_count;
        n_m_valid = r_m_valid;
        n_status  = r_status;
        n_out     = r_out;
        n_occ     = r_occ;
        if (m_tready) begin
            n_m_valid = 1'b0;
        end
        if (w_accept) begin
            n_m_valid = 1'b1;
            n_status  = ST_OK;
            n_out     = '0;
            unique case (w_cmd)
                CMD_ENQUEUE: begin
                    if (w_full) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
                CMD_DEQUEUE: begin
                    if (w_empty) begin
                        n_status = ST_UNDERFLOW;
                        n_out    = '1;
                    end else begin
                        n_out   = w_entry[0];
                        n_count = r_count - CW'(1);
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
            n_occ = OCC_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_out    <= n_out;
        r_occ    <= n_occ;
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {r_occ, r_out.prio, r_out.value};
    assign m_tuser  = r_status;

endmodule

/* rtl/spq_checker.sv */
// Port-level checks for the sorted priority queue, bound to the top level.
// Needs spq_pkg for the status codes.
module spq_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // An underflow can only be reported with an empty queue and all-ones data.
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == ST_UNDERFLOW) |->
            (m_tdata[47:0] == '1 && m_tdata[55:48] == '0))
        else $error("underflow result carries wrong data or occupancy");

    // An overflow leaves the queue full and returns zero data.
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == ST_OVERFLOW) |->
            (m_tdata[47:0] == '0 && m_tdata[55:48] == 8'(DEPTH)))
        else $error("overflow result carries wrong data or occupancy");

    // Each accepted request yields a result in the following cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted request produced no result");

    // A waiting result holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
